@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants, initial hash value and the sigma functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;
    typedef word_t [15:0] block_t;

    // One input item: a message byte and its framing flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } sha_in_t;

    // One result item: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Commands from the sequencer to the schedule buffer.
    typedef struct packed {
        logic wr_byte;
        logic pad;
        logic pad_len;
        logic clear_len;
        logic shift;
    } sched_cmd_t;

    localparam logic [5:0] LastRound  = 6'd63;
    localparam logic [5:0] LenPos     = 6'd56;
    localparam logic [7:0] PadByte    = 8'h80;
    localparam logic [2:0] LastWord   = 3'd7;

    function automatic hash_t init_hash();
        hash_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bsig0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t ssig0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constant table.
    function automatic word_t round_k(logic [5:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/sha_sched.sv @@
// ----------------------------------------------------------------------------
// SHA-256 schedule buffer
// Holds the 16-word message block, takes byte writes and padding, and rolls
// forward one schedule word per round with the expansion computed ahead.
// ----------------------------------------------------------------------------
module sha_sched (
    input  logic               aclk,
    input  sha_pkg::sched_cmd_t cmd,
    input  logic [7:0]         byte_in,
    input  logic [5:0]         pos,
    input  logic [63:0]        bit_len,
    output sha_pkg::word_t     w_out
);
    import sha_pkg::*;

    block_t     buf_reg;
    block_t     buf_next;
    logic [3:0] widx;
    logic [4:0] bsh;
    word_t      w_new;

    assign widx = pos[5:2];
    assign bsh  = {~pos[1:0], 3'b000};

    // Next schedule word, sixteen rounds ahead of the one at the head.
    assign w_new = ssig1(buf_reg[14]) + buf_reg[9] + ssig0(buf_reg[1]) + buf_reg[0];

    // Buffer update for the current command.
    always_comb begin
        buf_next = buf_reg;
        if (cmd.wr_byte) begin
            buf_next[widx][bsh +: 8] = byte_in;
        end
        if (cmd.pad) begin
            for (int i = 0; i < 16; i++) begin
                if (4'(i) == widx) begin
                    for (int b = 0; b < 4; b++) begin
                        if (2'(b) == pos[1:0]) begin
                            buf_next[i][(24 - 8 * b) +: 8] = PadByte;
                        end else if (2'(b) > pos[1:0]) begin
                            buf_next[i][(24 - 8 * b) +: 8] = 8'h00;
                        end
                    end
                end else if (4'(i) > widx) begin
                    buf_next[i] = '0;
                end
            end
        end
        if (cmd.clear_len) begin
            buf_next = '0;
        end
        if (cmd.pad_len || cmd.clear_len) begin
            buf_next[14] = bit_len[63:32];
            buf_next[15] = bit_len[31:0];
        end
        if (cmd.shift) begin
            for (int i = 0; i < 15; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            buf_next[15] = w_new;
        end
    end

    // Block storage; contents are meaningful only once written.
    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign w_out = buf_reg[0];

endmodule

@@ rtl/sha_round.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the working variables a..h and performs one compression round per
// cycle while step is high; reloads from the hash words at the start of a block.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic           aclk,
    input  logic           load,
    input  logic           step,
    input  sha_pkg::hash_t hash_in,
    input  sha_pkg::word_t k,
    input  sha_pkg::word_t w,
    output sha_pkg::hash_t vars
);
    import sha_pkg::*;

    hash_t v_reg;
    hash_t v_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    // Round functions on the current variables.
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + bsig1(v_reg[4]) + ch + k + w;
    assign t2  = bsig0(v_reg[0]) + maj;

    always_comb begin
        v_next = v_reg;
        if (load) begin
            v_next = hash_in;
        end else if (step) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

    assign vars = v_reg;

endmodule

@@ rtl/sha256_message_hasher_top.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message hasher, top level
// Byte-serial SHA-256: packs bytes into a block, runs the rounds on a shared
// round unit, pads the final block(s) and emits the eight digest words.
// ----------------------------------------------------------------------------
// Input: a byte that does not complete a block leaves the input ready; a byte that
//   completes a block keeps the input stalled through load, 64 rounds and the add.
// A last item adds a padding step before each of one or two compressions, then
//   8 digest items, one per cycle when the sink is ready.
// Throughput is set by the single round unit doing one round per cycle; the input
//   is stalled while a block is compressed.
// Reset: synchronous active low; loads the initial hash, clears the byte
//   position and bit length. The block buffer is not cleared.
module sha256_message_hasher_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sha_pkg::sha_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sha_pkg::sha_out_t m_data
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FIN,
        ST_PAD,
        ST_PAD2,
        ST_OUT
    } state_t;

    state_t      state_reg,     state_next;
    state_t      ret_reg,       ret_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [5:0]  pos_reg,       pos_next;
    logic [63:0] bit_len_reg,   bit_len_next;
    hash_t       hash_reg,      hash_next;
    logic [2:0]  idx_reg,       idx_next;
    logic        m_valid_reg,   m_valid_next;

    sched_cmd_t  cmd;
    logic        s_fire;
    logic        m_fire;
    logic        rnd_load;
    logic        rnd_step;
    word_t       w_cur;
    hash_t       vars;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_fire  = m_valid_reg && m_ready;

    // Result item is the head of the hash word rotation.
    assign m_data.digest_word = hash_reg[0];
    assign m_data.word_index  = idx_reg;
    assign m_data.last_word   = (idx_reg == LastWord);

    // Schedule buffer and round unit.
    sha_sched u_sched (
        .aclk    (aclk),
        .cmd     (cmd),
        .byte_in (s_data.data_byte),
        .pos     (pos_reg),
        .bit_len (bit_len_reg),
        .w_out   (w_cur)
    );

    sha_round u_round (
        .aclk    (aclk),
        .load    (rnd_load),
        .step    (rnd_step),
        .hash_in (hash_reg),
        .k       (round_k(round_cnt_reg)),
        .w       (w_cur),
        .vars    (vars)
    );

    // Sequencer: byte intake, compression, padding and digest output.
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_cnt_next = round_cnt_reg;
        pos_next       = pos_reg;
        bit_len_next   = bit_len_reg;
        hash_next      = hash_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        cmd            = '0;
        rnd_load       = 1'b0;
        rnd_step       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.has_byte) begin
                        cmd.wr_byte  = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        bit_len_next = bit_len_reg + 64'd8;
                    end
                    if (s_data.has_byte && pos_reg == LastRound) begin
                        state_next = ST_LOAD;
                        ret_next   = s_data.is_last ? ST_PAD : ST_IDLE;
                    end else if (s_data.is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD: begin
                rnd_load       = 1'b1;
                round_cnt_next = '0;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                rnd_step       = 1'b1;
                cmd.shift      = 1'b1;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == LastRound) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + vars[i];
                end
                state_next = ret_reg;
                if (ret_reg == ST_OUT) begin
                    m_valid_next = 1'b1;
                    idx_next     = '0;
                end
            end
            ST_PAD: begin
                cmd.pad    = 1'b1;
                state_next = ST_LOAD;
                if (pos_reg < LenPos) begin
                    cmd.pad_len = 1'b1;
                    ret_next    = ST_OUT;
                end else begin
                    ret_next    = ST_PAD2;
                end
            end
            ST_PAD2: begin
                cmd.clear_len = 1'b1;
                ret_next      = ST_OUT;
                state_next    = ST_LOAD;
            end
            ST_OUT: begin
                if (m_fire) begin
                    idx_next = idx_reg + 3'd1;
                    for (int i = 0; i < 7; i++) begin
                        hash_next[i] = hash_reg[i + 1];
                    end
                    hash_next[7] = hash_reg[0];
                    if (idx_reg == LastWord) begin
                        hash_next    = init_hash();
                        pos_next     = '0;
                        bit_len_next = '0;
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_cnt_reg <= '0;
            pos_reg       <= '0;
            bit_len_reg   <= '0;
            hash_reg      <= init_hash();
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_cnt_reg <= round_cnt_next;
            pos_reg       <= pos_next;
            bit_len_reg   <= bit_len_next;
            hash_reg      <= hash_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // The block never takes an item while digest words are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest output is pending");

    // The hash update follows only the final round.
    a_fin_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |->
            ($past(state_reg) == ST_ROUND && $past(round_cnt_reg) == LastRound))
        else $error("hash update without a full set of rounds");

    // After the last digest word the block is ready with empty counters.
    a_clean_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_data.last_word) |=>
            (s_ready && pos_reg == '0 && bit_len_reg == '0))
        else $error("block did not return to its initial state");

endmodule

@@ tb/sv/tb_sha256_message_hasher_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the byte-serial SHA-256 message hasher
// Feeds messages one byte per item through the valid/ready input channel and
// checks every digest word against a SHA-256 computation kept in the bench.
// It starts with a few directed messages: the empty message, "abc", an empty
// final item after bytes and ignored items. Random messages follow, with
// lengths around the block and padding boundaries. The sender idles in bursts,
// and the receiver stalls on its own pattern with one long hold-off.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_top;

    import sha_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int EndCycles     = 300;
    localparam int HoldAtWord    = 44;
    localparam int HoldCycles    = 600;
    localparam int TargetItems   = 430;

    // SHA-256 round constants, element 0 first.
    localparam logic [0:63][31:0] RoundK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash value H0..H7.
    localparam logic [0:7][31:0] StartHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadMarker = 8'h80;
    localparam int         LenStart  = 56;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sha_in_t   s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sha_out_t  m_data;

    sha256_message_hasher_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Items waiting to be sent, with a flag that holds the sender until every
    // digest word so far has arrived.
    sha_in_t  msg_item_q[$];
    bit       wait_idle_q[$];
    // Digest words the hasher should return, oldest first.
    sha_out_t digest_words_q[$];

    // Hash state kept by the bench.
    logic [31:0] hash_st [8];
    logic [31:0] blk_words [16];
    logic [5:0]  byte_pos;
    logic [63:0] msg_bits;

    int n_errors    = 0;
    int n_items     = 0;
    int n_msgs      = 0;
    int n_empty     = 0;
    int n_full_end  = 0;
    int n_two_blk   = 0;
    int n_ignored   = 0;
    int n_bytes     = 0;
    int n_words     = 0;
    int n_waits     = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    logic [15:0] rx_cycle = '0;
    sha_out_t want;

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_errors++;
    endtask

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // Runs the 64 rounds on the current block and adds into the hash.
    function automatic void run_rounds();
        logic [31:0] w [16];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
        logic [31:0] t1, t2, wr, x2, x15;
        int r;
        int i;
        for (i = 0; i < 16; i++) w[i] = blk_words[i];
        va = hash_st[0]; vb = hash_st[1]; vc = hash_st[2]; vd = hash_st[3];
        ve = hash_st[4]; vf = hash_st[5]; vg = hash_st[6]; vh = hash_st[7];
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                x2  = w[(r - 2) & 15];
                x15 = w[(r - 15) & 15];
                wr  = (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10))
                    + w[(r - 7) & 15]
                    + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
                    + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + RoundK[r] + wr;
            t2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        hash_st[0] += va; hash_st[1] += vb; hash_st[2] += vc; hash_st[3] += vd;
        hash_st[4] += ve; hash_st[5] += vf; hash_st[6] += vg; hash_st[7] += vh;
    endfunction

    // Bytes fill each block word big-endian.
    function automatic void place_byte(input int pos, input logic [7:0] b);
        blk_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++) hash_st[i] = StartHash[i];
        byte_pos = '0;
        msg_bits = '0;
    endfunction

    // Takes one accepted item into the hash and queues the digest on a last.
    function automatic void absorb_item(input sha_in_t it);
        int p;
        int i;
        sha_out_t dw;
        if (!it.has_byte && !it.is_last) n_ignored++;
        if (it.has_byte) begin
            place_byte(byte_pos, it.data_byte);
            msg_bits += 64'd8;
            byte_pos = byte_pos + 6'd1;
            n_bytes++;
            if (byte_pos == 6'd0) run_rounds();
        end
        if (it.is_last) begin
            p = byte_pos;
            n_msgs++;
            if (msg_bits == 64'd0) n_empty++;
            else if (p == 0) n_full_end++;
            place_byte(p, PadMarker);
            for (i = p + 1; i < 64; i++) place_byte(i, 8'h00);
            if (p >= LenStart) begin
                n_two_blk++;
                run_rounds();
                for (i = 0; i < 16; i++) blk_words[i] = '0;
            end
            blk_words[14] = msg_bits[63:32];
            blk_words[15] = msg_bits[31:0];
            run_rounds();
            for (i = 0; i < 8; i++) begin
                dw.digest_word = hash_st[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (i == 7);
                digest_words_q.push_back(dw);
            end
            restart_hash();
        end
    endfunction

    task automatic push_item(input logic [7:0] d, input logic hb, input logic lst,
                             input bit hold_idle);
        sha_in_t it;
        it.data_byte = d;
        it.has_byte  = hb;
        it.is_last   = lst;
        msg_item_q.push_back(it);
        wait_idle_q.push_back(hold_idle);
        if (hb || lst) n_items++;
        if (hold_idle) n_waits++;
    endtask

    // One message of random bytes with some ignored items mixed in. With
    // empty_end set, the bytes are followed by a byteless final item.
    task automatic add_message(input int len, input bit empty_end, input bit hold_idle);
        int i;
        bit first;
        first = hold_idle;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            push_item(8'($urandom_range(0, 255)), 1'b1,
                      !empty_end && (i == len - 1), first);
            first = 1'b0;
        end
        if (empty_end || len == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
    endtask

    // Driver: offers items in bursts with random gaps, and holds back an item
    // flagged to wait until all digest words so far have come out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_item(s_data);
            if (!s_valid || s_ready) begin
                if (msg_item_q.size() != 0 && gap_left == 0 &&
                    !(wait_idle_q[0] && digest_words_q.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_data  <= msg_item_q.pop_front();
                    void'(wait_idle_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left != 0) gap_left = gap_left - 1;
                end
            end
        end
    end

    // Monitor: checks each digest word and drives the receiver's stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_words++;
                if (digest_words_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected digest word %h index %0d",
                                            m_data.digest_word, m_data.word_index));
                end else begin
                    want = digest_words_q.pop_front();
                    if (m_data.digest_word !== want.digest_word)
                        note_mismatch($sformatf("digest_word %h, expected %h",
                                                m_data.digest_word, want.digest_word));
                    if (m_data.word_index !== want.word_index)
                        note_mismatch($sformatf("word_index %0d, expected %0d",
                                                m_data.word_index, want.word_index));
                    if (m_data.last_word !== want.last_word)
                        note_mismatch($sformatf("last_word %b, expected %b",
                                                m_data.last_word, want.last_word));
                end
                // One long hold-off in the middle of a digest.
                if (n_words == HoldAtWord) hold_left = HoldCycles;
            end
            rx_cycle <= rx_cycle + 16'd1;
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                case (rx_cycle[9:8])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= 1'($urandom_range(0, 1));
                    2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= rx_cycle[1];
                endcase
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WatchdogLimit) begin
                $display("[%0t] watchdog: no item moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int msg_idx;
        int pick;
        int len;
        restart_hash();

        // Directed: empty message, an ignored item, "abc".
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        // Extreme bytes, an ignored item, then a byteless final item.
        push_item(8'h00, 1'b1, 1'b0, 1'b1);
        push_item(8'hff, 1'b1, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b0);

        // Boundary lengths: last byte fills a block, padding from position 56, a byteless
        // end at 55 or after a full block, padding from 63, and a block plus 56 bytes.
        add_message(64, 1'b0, 1'b0);
        add_message(56, 1'b0, 1'b0);
        add_message(55, 1'b1, 1'b0);
        add_message(64, 1'b1, 1'b0);
        add_message(63, 1'b0, 1'b0);
        add_message(120, 1'b0, 1'b0);

        // Random messages, mostly short, some around the block boundaries.
        msg_idx = 0;
        while (n_items < TargetItems) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) len = $urandom_range(0, 12);
            else if (pick < 6) len = $urandom_range(52, 70);
            else if (pick == 6) len = $urandom_range(110, 135);
            else len = $urandom_range(13, 51);
            add_message(len, ($urandom_range(0, 3) == 0), (msg_idx % 6 == 5));
            msg_idx++;
        end
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (msg_item_q.size() != 0 || s_valid) @(posedge aclk);
        while (digest_words_q.size() != 0) @(posedge aclk);
        repeat (EndCycles) @(posedge aclk);

        $display("Hashed %0d messages, %0d bytes: %0d empty, %0d ending on a full block,",
                 n_msgs, n_bytes, n_empty, n_full_end);
        $display("%0d with a second pad block, %0d ignored items, %0d drain pauses, %0d words checked.",
                 n_two_blk, n_ignored, n_waits, n_words);
        if (n_errors == 0 && digest_words_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sha_pkg.sv
rtl/sha_sched.sv
rtl/sha_round.sv
rtl/sha256_message_hasher_top.sv
tb/sv/tb_sha256_message_hasher_top.sv
